// ===== design/jmec_pkg.sv =====
// Package with the constants, types and sequencer states of the jackknife unit.
`default_nettype none
package jmec_pkg;
  localparam int MAX_SAMPLES = 1024;
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = 24;
  localparam int SUM_W = SW + 11;
  localparam int DIF_W = SW + 1;
  localparam int PRD_W = 2 * DIF_W;
  localparam int ACC_W = 60;
  localparam int ROOT_W = ACC_W / 2;
  localparam int ERR_W = 25;
  localparam int DIV_CNT_W = $clog2(ACC_W);
  localparam int SQ_CNT_W = $clog2(ROOT_W);
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 176;

  typedef enum logic [4:0] {
    S_IDLE, S_MA_GO, S_MA_W, S_MB_GO, S_MB_W, S_RD, S_DIFF, S_MAC,
    S_SA_GO, S_SA_W, S_SB_GO, S_SB_W, S_SC_GO, S_SC_W,
    S_QA_GO, S_QA_W, S_QB_GO, S_QB_W, S_DONE
  } state_e;
endpackage
`default_nettype wire

// ===== design/jmec_store.sv =====
// Sample memory holding the paired A and B samples of one set.
`default_nettype none
module jmec_store (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [jmec_pkg::AW-1:0]             waddr_i,
  input  wire logic [jmec_pkg::IN_DATA_W-1:0]      wdata_i,
  input  wire logic                                re_i,
  input  wire logic [jmec_pkg::AW-1:0]             raddr_i,
  output logic      [jmec_pkg::IN_DATA_W-1:0]      rdata_o
);
  logic [jmec_pkg::IN_DATA_W-1:0] mem_q [jmec_pkg::MAX_SAMPLES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== design/jmec_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned dividend by sample count.
`default_nettype none
module jmec_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [jmec_pkg::ACC_W-1:0]    dividend_i,
  input  wire logic [jmec_pkg::CW-1:0]       divisor_i,
  output logic                               done_o,
  output logic      [jmec_pkg::ACC_W-1:0]    quotient_o,
  output logic      [jmec_pkg::CW-1:0]       remainder_o
);
  logic                             busy_q;
  logic [jmec_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [jmec_pkg::ACC_W-1:0]       dvd_q;
  logic [jmec_pkg::CW-1:0]          rem_q;
  logic [jmec_pkg::CW:0]            trial;
  logic                             fits;

  assign trial = {rem_q, dvd_q[jmec_pkg::ACC_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == jmec_pkg::DIV_CNT_W'(jmec_pkg::ACC_W - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[jmec_pkg::ACC_W-2:0], fits};
      rem_q <= fits ? jmec_pkg::CW'(trial - {1'b0, divisor_i}) : trial[jmec_pkg::CW-1:0];
    end
  end

  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;
endmodule
`default_nettype wire

// ===== design/jmec_sqrt.sv =====
// Digit-by-digit floored square root, one root bit per cycle.
`default_nettype none
module jmec_sqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [jmec_pkg::ACC_W-1:0]    operand_i,
  output logic                               done_o,
  output logic      [jmec_pkg::ROOT_W-1:0]   root_o
);
  logic                            busy_q;
  logic [jmec_pkg::SQ_CNT_W-1:0]   cnt_q;
  logic [jmec_pkg::ACC_W-1:0]      op_q;
  logic [jmec_pkg::ROOT_W+1:0]     rem_q;
  logic [jmec_pkg::ROOT_W-1:0]     root_q;
  logic [jmec_pkg::ROOT_W+3:0]     rem_s;
  logic [jmec_pkg::ROOT_W+3:0]     trial;
  logic                            fits;

  assign rem_s = {rem_q, op_q[jmec_pkg::ACC_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign fits  = rem_s >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == jmec_pkg::SQ_CNT_W'(jmec_pkg::ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q   <= operand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      op_q   <= {op_q[jmec_pkg::ACC_W-3:0], 2'b00};
      rem_q  <= fits ? (jmec_pkg::ROOT_W+2)'(rem_s - trial) : rem_s[jmec_pkg::ROOT_W+1:0];
      root_q <= {root_q[jmec_pkg::ROOT_W-2:0], fits};
    end
  end

  assign root_o = root_q;
endmodule
`default_nettype wire

// ===== design/jackknife_mean_error_covariance.sv =====
// Top level of the jackknife mean, error and covariance unit.
// Usage: paired samples (A in tdata[23:0], B in tdata[47:24], Q8.16) arrive on the
// slave stream, one word per cycle while tready is high. Each word is stored in the
// sample memory and added to the running sums. A word with tlast set closes the set
// and starts the evaluation; tready stays low until it is finished.
// Evaluation: two divisions for the means (start, 60 quotient bits, done), then
// one pass over the stored set (memory read, deviation, three products on one
// shared multiplier), three divisions for the (N-1)/N scaling and two square
// roots. The result word waits in an output register; the next set may stream in
// while the receiver stalls, and a new evaluation only waits for that register at
// its end. Samples beyond the memory depth are dropped and reported in tuser.
// Reset clears the count, the sums and the drop flag; memory contents need no clear.
`default_nettype none
module jackknife_mean_error_covariance (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // sample_a [23:0], sample_b [47:24]
  input  wire logic [jmec_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // last
  input  wire logic                                 s_axis_tlast_i,
  output logic                                      m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  // mean_a [23:0], mean_b [47:24], error_a [72:48], error_b [97:73],
  // covariance_ab [157:98], sample_count [168:158], zero fill above
  output logic      [jmec_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // overflowed
  output logic                                      m_axis_tuser_o
);
  localparam int SW    = jmec_pkg::SW;
  localparam int ACC_W = jmec_pkg::ACC_W;
  localparam int CW    = jmec_pkg::CW;

  jmec_pkg::state_e state_q, state_d;

  logic                            accept;
  logic [CW-1:0]                   fill_q;
  logic signed [jmec_pkg::SUM_W-1:0] sum_a_q, sum_b_q;
  logic                            drop_q;
  logic [CW-1:0]                   idx_q;
  logic [1:0]                      mph_q;
  logic signed [SW-1:0]            mean_a_q, mean_b_q;
  logic signed [jmec_pkg::DIF_W-1:0] da_q, db_q, mul_x, mul_y;
  logic signed [jmec_pkg::PRD_W-1:0] prod_q;
  logic [ACC_W-1:0]                ssa_q, ssb_q, sa_q, sb_q, cm_q;
  logic signed [ACC_W-1:0]         cov_q;
  logic [ACC_W-1:0]                cmag;
  logic [jmec_pkg::ERR_W-1:0]      err_a_q, err_b_q;
  logic [jmec_pkg::SUM_W-1:0]      mag_a, mag_b;
  logic                            out_valid_q;
  logic [jmec_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                            out_user_q;

  logic                            div_start, div_done;
  logic [ACC_W-1:0]                div_dvd, div_quo, scaled;
  logic [ACC_W-1:0]                dvd_hold;
  logic [CW-1:0]                   div_rem;
  logic                            sq_start, sq_done;
  logic [ACC_W-1:0]                sq_op;
  logic [jmec_pkg::ROOT_W-1:0]     sq_root;
  logic [jmec_pkg::ERR_W-1:0]      err_sat;
  logic                            mem_re;
  logic [jmec_pkg::IN_DATA_W-1:0]  rd_data;
  logic [ACC_W-1:0]                cov_sat;
  logic signed [ACC_W-1:0]         cov_out;

  assign s_axis_tready_o = (state_q == jmec_pkg::S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign mag_a  = sum_a_q[jmec_pkg::SUM_W-1] ? jmec_pkg::SUM_W'(-sum_a_q) : sum_a_q;
  assign mag_b  = sum_b_q[jmec_pkg::SUM_W-1] ? jmec_pkg::SUM_W'(-sum_b_q) : sum_b_q;
  assign cmag   = cov_q[ACC_W-1] ? ACC_W'(-cov_q) : cov_q;

  // The dividend of the running scaling step, held while the divider works.
  always_comb begin
    case (state_q)
      jmec_pkg::S_SA_W: dvd_hold = ssa_q;
      jmec_pkg::S_SB_W: dvd_hold = ssb_q;
      jmec_pkg::S_SC_W: dvd_hold = cmag;
      default:          dvd_hold = '0;
    endcase
  end

  // floor((N-1)*m/N) = m - ceil(m/N)
  assign scaled = ACC_W'(dvd_hold - div_quo - ACC_W'(div_rem != '0));

  assign err_sat = (sq_root > jmec_pkg::ROOT_W'(1 << 24)) ? jmec_pkg::ERR_W'(1 << 24)
                                                          : sq_root[jmec_pkg::ERR_W-1:0];
  assign cov_sat = (cm_q > (ACC_W'(1) << 58)) ? (ACC_W'(1) << 58) : cm_q;
  assign cov_out = cov_q[ACC_W-1] ? ACC_W'(-cov_sat) : cov_sat;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      jmec_pkg::S_IDLE:  if (accept && s_axis_tlast_i) state_d = jmec_pkg::S_MA_GO;
      jmec_pkg::S_MA_GO: state_d = jmec_pkg::S_MA_W;
      jmec_pkg::S_MA_W:  if (div_done) state_d = jmec_pkg::S_MB_GO;
      jmec_pkg::S_MB_GO: state_d = jmec_pkg::S_MB_W;
      jmec_pkg::S_MB_W:  if (div_done) state_d = jmec_pkg::S_RD;
      jmec_pkg::S_RD:    state_d = jmec_pkg::S_DIFF;
      jmec_pkg::S_DIFF:  state_d = jmec_pkg::S_MAC;
      jmec_pkg::S_MAC: begin
        if (mph_q == 2'd3) begin
          state_d = (idx_q + 1'b1 == fill_q) ? jmec_pkg::S_SA_GO : jmec_pkg::S_RD;
        end
      end
      jmec_pkg::S_SA_GO: state_d = jmec_pkg::S_SA_W;
      jmec_pkg::S_SA_W:  if (div_done) state_d = jmec_pkg::S_SB_GO;
      jmec_pkg::S_SB_GO: state_d = jmec_pkg::S_SB_W;
      jmec_pkg::S_SB_W:  if (div_done) state_d = jmec_pkg::S_SC_GO;
      jmec_pkg::S_SC_GO: state_d = jmec_pkg::S_SC_W;
      jmec_pkg::S_SC_W:  if (div_done) state_d = jmec_pkg::S_QA_GO;
      jmec_pkg::S_QA_GO: state_d = jmec_pkg::S_QA_W;
      jmec_pkg::S_QA_W:  if (sq_done) state_d = jmec_pkg::S_QB_GO;
      jmec_pkg::S_QB_GO: state_d = jmec_pkg::S_QB_W;
      jmec_pkg::S_QB_W:  if (sq_done) state_d = jmec_pkg::S_DONE;
      jmec_pkg::S_DONE:  if (!out_valid_q) state_d = jmec_pkg::S_IDLE;
      default:           state_d = jmec_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: unit starts, operand selection, memory read.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    sq_start  = 1'b0;
    sq_op     = '0;
    mem_re    = 1'b0;
    case (state_q)
      jmec_pkg::S_MA_GO: begin
        div_start = 1'b1;
        div_dvd   = ACC_W'(mag_a);
      end
      jmec_pkg::S_MB_GO: begin
        div_start = 1'b1;
        div_dvd   = ACC_W'(mag_b);
      end
      jmec_pkg::S_SA_GO: begin
        div_start = 1'b1;
        div_dvd   = ssa_q;
      end
      jmec_pkg::S_SB_GO: begin
        div_start = 1'b1;
        div_dvd   = ssb_q;
      end
      jmec_pkg::S_SC_GO: begin
        div_start = 1'b1;
        div_dvd   = cmag;
      end
      jmec_pkg::S_QA_GO: begin
        sq_start = 1'b1;
        sq_op    = sa_q;
      end
      jmec_pkg::S_QB_GO: begin
        sq_start = 1'b1;
        sq_op    = sb_q;
      end
      jmec_pkg::S_RD: mem_re = 1'b1;
      default: ;
    endcase
  end

  // The single multiplier serves the three products of a sample in turn.
  always_comb begin
    case (mph_q)
      2'd0:    begin mul_x = da_q; mul_y = da_q; end
      2'd1:    begin mul_x = db_q; mul_y = db_q; end
      default: begin mul_x = da_q; mul_y = db_q; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jmec_pkg::S_IDLE;
      fill_q      <= '0;
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      mph_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        jmec_pkg::S_IDLE: begin
          if (accept) begin
            if (fill_q < CW'(jmec_pkg::MAX_SAMPLES)) begin
              fill_q  <= fill_q + 1'b1;
              sum_a_q <= sum_a_q + jmec_pkg::SUM_W'($signed(s_axis_tdata_i[SW-1:0]));
              sum_b_q <= sum_b_q + jmec_pkg::SUM_W'($signed(s_axis_tdata_i[2*SW-1:SW]));
            end else begin
              drop_q <= 1'b1;
            end
            idx_q <= '0;
          end
        end
        jmec_pkg::S_DIFF: mph_q <= '0;
        jmec_pkg::S_MAC: begin
          mph_q <= mph_q + 1'b1;
          if (mph_q == 2'd3) idx_q <= idx_q + 1'b1;
        end
        jmec_pkg::S_DONE: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            fill_q      <= '0;
            sum_a_q     <= '0;
            sum_b_q     <= '0;
            drop_q      <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      jmec_pkg::S_IDLE: begin
        ssa_q <= '0;
        ssb_q <= '0;
        cov_q <= '0;
      end
      jmec_pkg::S_MA_W: if (div_done) begin
        mean_a_q <= sum_a_q[jmec_pkg::SUM_W-1] ? SW'(-div_quo[SW-1:0]) : div_quo[SW-1:0];
      end
      jmec_pkg::S_MB_W: if (div_done) begin
        mean_b_q <= sum_b_q[jmec_pkg::SUM_W-1] ? SW'(-div_quo[SW-1:0]) : div_quo[SW-1:0];
      end
      jmec_pkg::S_DIFF: begin
        da_q <= jmec_pkg::DIF_W'($signed(rd_data[SW-1:0])) - jmec_pkg::DIF_W'(mean_a_q);
        db_q <= jmec_pkg::DIF_W'($signed(rd_data[2*SW-1:SW])) - jmec_pkg::DIF_W'(mean_b_q);
      end
      jmec_pkg::S_MAC: begin
        prod_q <= mul_x * mul_y;
        case (mph_q)
          2'd1:    ssa_q <= ssa_q + ACC_W'(prod_q);
          2'd2:    ssb_q <= ssb_q + ACC_W'(prod_q);
          2'd3:    cov_q <= cov_q + ACC_W'(prod_q);
          default: ;
        endcase
      end
      jmec_pkg::S_SA_W: if (div_done) sa_q <= scaled;
      jmec_pkg::S_SB_W: if (div_done) sb_q <= scaled;
      jmec_pkg::S_SC_W: if (div_done) cm_q <= scaled;
      jmec_pkg::S_QA_W: if (sq_done) err_a_q <= err_sat;
      jmec_pkg::S_QB_W: if (sq_done) err_b_q <= err_sat;
      jmec_pkg::S_DONE: begin
        if (!out_valid_q) begin
          out_data_q <= {7'd0, fill_q, cov_out, err_b_q, err_a_q, mean_b_q, mean_a_q};
          out_user_q <= drop_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  jmec_store u_store (
    .clk_i   (clk_i),
    .we_i    (accept && (fill_q < CW'(jmec_pkg::MAX_SAMPLES))),
    .waddr_i (fill_q[jmec_pkg::AW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .re_i    (mem_re),
    .raddr_i (idx_q[jmec_pkg::AW-1:0]),
    .rdata_o (rd_data)
  );

  jmec_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (fill_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  jmec_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .operand_i (sq_op),
    .done_o    (sq_done),
    .root_o    (sq_root)
  );

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(jmec_pkg::MAX_SAMPLES))
    else $error("sample count beyond memory depth");
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> fill_q == CW'(jmec_pkg::MAX_SAMPLES))
    else $error("drop flag set with room left");
  a_pass_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == jmec_pkg::S_MAC |-> idx_q < fill_q)
    else $error("pass index beyond stored set");
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == jmec_pkg::S_DONE))
    else $error("result word raised outside the final step");
`endif
endmodule
`default_nettype wire
